[rtl/core/pmi_pkg.sv]
// Shared types, constants and the control-store contents of the point-mass integrator.
`default_nettype none

package pmi_pkg;

    // Field widths of the stream items and the configuration port.
    localparam int POS_W      = 48;
    localparam int VEL_W      = 40;
    localparam int ACC_IN_W   = 32;
    localparam int DT_W       = 32;
    localparam int KIND_W     = 2;
    localparam int METHOD_W   = 2;
    localparam int POINTS_W   = 14;
    localparam int SLOT_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 208;

    // Shared multiplier: operands are taken in two halves of a 48-bit word.
    localparam int Q_FRAC  = 16;
    localparam int OP_W    = 48;
    localparam int HALF_W  = OP_W / 2;
    localparam int PROD_W  = (HALF_W + 1) + (DT_W + 1);
    localparam int ACC_W   = 84;
    localparam int SUM_W   = ACC_W - Q_FRAC;

    localparam int TRAIL_DEPTH_DEF = 8192;

    localparam logic [DT_W-1:0] TIMESTEP_RST = 32'd65536;

    // Item kinds carried in tuser.
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Integration methods; any code other than Euler runs the Verlet program.
    localparam logic [METHOD_W-1:0] METHOD_EULER = 2'd0;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESTEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL    = 2'd3;

    // Control store addresses.
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UA_VERLET = 5'd0;
    localparam logic [UPC_W-1:0] UA_EULER  = 5'd11;
    localparam logic [UPC_W-1:0] UA_COMMIT = 5'd21;
    localparam logic [UPC_W-1:0] UA_EMIT   = 5'd22;

    typedef enum logic [1:0] {SRC_ACCEL, SRC_VEL, SRC_DV} mul_src_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI} acc_op_t;
    typedef enum logic [2:0] {SUM_HOLD, SUM_VEL_Q, SUM_POS_Q, SUM_ADD_QH, SUM_VEL_DV} sum_op_t;
    typedef enum logic [1:0] {WR_NONE, WR_VEL, WR_POS, WR_COMMIT} wr_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_AXIS, SEQ_EMIT} seq_op_t;

    typedef struct packed {
        mul_src_t         mul_src;
        logic             mul_hi;
        acc_op_t          acc_op;
        sum_op_t          sum_op;
        logic             dv_we;
        wr_op_t           wr_op;
        seq_op_t          seq_op;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   axis;
    } seq_ctl_t;

    function automatic ucode_t uc(
        input mul_src_t         src,
        input logic             hi,
        input acc_op_t          ao,
        input sum_op_t          so,
        input logic             dv,
        input wr_op_t           wr,
        input seq_op_t          sq,
        input logic [UPC_W-1:0] tgt
    );
        ucode_t w;
        w.mul_src = src;
        w.mul_hi  = hi;
        w.acc_op  = ao;
        w.sum_op  = so;
        w.dv_we   = dv;
        w.wr_op   = wr;
        w.seq_op  = sq;
        w.target  = tgt;
        return w;
    endfunction

    // One axis per pass; the axis jump repeats the section for y.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        case (addr)
            // Verlet-like: dv = a*dt, p += v*dt + (dv*dt)/2, v += dv.
            5'd0:  w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd1:  w = uc(SRC_ACCEL, 1'b1, ACC_LOAD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd2:  w = uc(SRC_ACCEL, 1'b0, ACC_ADD_HI, SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd3:  w = uc(SRC_VEL,   1'b0, ACC_HOLD,   SUM_HOLD,   1'b1, WR_NONE, SEQ_NEXT, '0);
            5'd4:  w = uc(SRC_VEL,   1'b1, ACC_LOAD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd5:  w = uc(SRC_DV,    1'b0, ACC_ADD_HI, SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd6:  w = uc(SRC_DV,    1'b1, ACC_LOAD,   SUM_POS_Q,  1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd7:  w = uc(SRC_ACCEL, 1'b0, ACC_ADD_HI, SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd8:  w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_ADD_QH, 1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd9:  w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_VEL_DV, 1'b0, WR_POS,  SEQ_NEXT, '0);
            5'd10: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_VEL,  SEQ_AXIS,
                          UA_VERLET);
            // Symplectic Euler: v += a*dt, then p += v*dt with the new v.
            5'd11: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd12: w = uc(SRC_ACCEL, 1'b1, ACC_LOAD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd13: w = uc(SRC_ACCEL, 1'b0, ACC_ADD_HI, SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd14: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_VEL_Q,  1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd15: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_VEL,  SEQ_NEXT, '0);
            5'd16: w = uc(SRC_VEL,   1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd17: w = uc(SRC_VEL,   1'b1, ACC_LOAD,   SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd18: w = uc(SRC_ACCEL, 1'b0, ACC_ADD_HI, SUM_HOLD,   1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd19: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_POS_Q,  1'b0, WR_NONE, SEQ_NEXT, '0);
            5'd20: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_POS,  SEQ_AXIS,
                          UA_EULER);
            // Common tail: apply load, clear or trail update, then hand out the beat.
            5'd21: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD,   SUM_HOLD,   1'b0, WR_COMMIT, SEQ_NEXT, '0);
            default: w = uc(SRC_ACCEL, 1'b0, ACC_HOLD, SUM_HOLD,   1'b0, WR_NONE, SEQ_EMIT, '0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pmi_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module pmi_ram
    import pmi_pkg::*;
#(
    parameter int WIDTH = 2 * POS_W,
    parameter int DEPTH = TRAIL_DEPTH_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/pmi_seq.sv]
// Microprogram sequencer: step counter, axis pass and control-store lookup.
`default_nettype none

module pmi_seq
    import pmi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [UPC_W-1:0] entry,
    input  wire logic             emit_ok,
    output logic                  busy,
    output logic                  emit,
    output seq_ctl_t              ctl
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             axis_reg, axis_next;
    logic             busy_reg, busy_next;
    ucode_t           word;

    assign word = ucode_rom(upc_reg);

    always_comb
    begin
        upc_next  = upc_reg;
        axis_next = axis_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                upc_next  = entry;
                axis_next = 1'b0;
            end
        end
        else
        begin
            case (word.seq_op)
                SEQ_NEXT:
                begin
                    upc_next = upc_reg + 1'b1;
                end
                SEQ_AXIS:
                begin
                    // The x pass repeats once for y, then the tail runs.
                    if (!axis_reg)
                    begin
                        upc_next  = word.target;
                        axis_next = 1'b1;
                    end
                    else
                    begin
                        upc_next  = UA_COMMIT;
                        axis_next = 1'b0;
                    end
                end
                SEQ_EMIT:
                begin
                    if (emit_ok)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    upc_next = UA_EMIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= UA_EMIT;
            axis_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            axis_reg <= axis_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign emit     = busy_reg && (word.seq_op == SEQ_EMIT) && emit_ok;
    assign ctl.uc   = word;
    assign ctl.axis = axis_reg;

endmodule

`default_nettype wire

[rtl/core/pmi_dp.sv]
// Datapath: shared multiplier, product accumulator, adder, saturation and state.
`default_nettype none

module pmi_dp
    import pmi_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire seq_ctl_t                   ctl,
    input  wire logic                       active,
    input  wire logic                       clear_sat,
    input  wire logic                       load_en,
    input  wire logic        [DT_W-1:0]     timestep,
    input  wire logic signed [ACC_IN_W-1:0] accel_x,
    input  wire logic signed [ACC_IN_W-1:0] accel_y,
    input  wire logic signed [POS_W-1:0]    load_pos_x,
    input  wire logic signed [POS_W-1:0]    load_pos_y,
    input  wire logic signed [VEL_W-1:0]    load_vel_x,
    input  wire logic signed [VEL_W-1:0]    load_vel_y,
    output logic signed      [POS_W-1:0]    pos_x,
    output logic signed      [POS_W-1:0]    pos_y,
    output logic signed      [VEL_W-1:0]    vel_x,
    output logic signed      [VEL_W-1:0]    vel_y,
    output logic                            saturated
);

    logic signed [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [VEL_W-1:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic signed [OP_W-1:0]   dv_reg, dv_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     sat_reg, sat_next;

    logic signed [ACC_IN_W-1:0] accel_cur;
    logic signed [POS_W-1:0]    pos_cur;
    logic signed [VEL_W-1:0]    vel_cur;
    logic signed [OP_W-1:0]     op;
    logic signed [HALF_W:0]     mul_a;
    logic signed [DT_W:0]       mul_b;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [SUM_W-1:0]    q;
    logic signed [SUM_W-1:0]    qh;
    logic signed [SUM_W-1:0]    pos_ext, vel_ext, dv_ext;
    logic                       pos_clip, vel_clip;
    logic signed [POS_W-1:0]    pos_sat;
    logic signed [VEL_W-1:0]    vel_sat;

    assign accel_cur = ctl.axis ? accel_y : accel_x;
    assign pos_cur   = ctl.axis ? py_reg : px_reg;
    assign vel_cur   = ctl.axis ? vy_reg : vx_reg;

    always_comb
    begin
        case (ctl.uc.mul_src)
            SRC_ACCEL: op = {{(OP_W - ACC_IN_W){accel_cur[ACC_IN_W-1]}}, accel_cur};
            SRC_VEL:   op = {{(OP_W - VEL_W){vel_cur[VEL_W-1]}}, vel_cur};
            SRC_DV:    op = dv_reg;
            default:   op = '0;
        endcase
    end

    // The low half is unsigned, the high half carries the sign.
    assign mul_a     = ctl.uc.mul_hi ? {op[OP_W-1], op[OP_W-1:HALF_W]}
                                     : {1'b0, op[HALF_W-1:0]};
    assign mul_b     = {1'b0, timestep};
    assign prod_next = mul_a * mul_b;

    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Dropping the fraction bits of the product floors toward minus infinity.
    assign q       = acc_reg[ACC_W-1:Q_FRAC];
    assign qh      = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:Q_FRAC+1]};
    assign pos_ext = {{(SUM_W - POS_W){pos_cur[POS_W-1]}}, pos_cur};
    assign vel_ext = {{(SUM_W - VEL_W){vel_cur[VEL_W-1]}}, vel_cur};
    assign dv_ext  = {{(SUM_W - OP_W){dv_reg[OP_W-1]}}, dv_reg};

    always_comb
    begin
        case (ctl.uc.acc_op)
            ACC_LOAD:   acc_next = prod_ext;
            ACC_ADD_HI: acc_next = acc_reg + (prod_ext <<< HALF_W);
            default:    acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.uc.sum_op)
            SUM_VEL_Q:  sum_next = vel_ext + q;
            SUM_POS_Q:  sum_next = pos_ext + q;
            SUM_ADD_QH: sum_next = sum_reg + qh;
            SUM_VEL_DV: sum_next = vel_ext + dv_ext;
            default:    sum_next = sum_reg;
        endcase
    end

    assign dv_next = ctl.uc.dv_we ? q[OP_W-1:0] : dv_reg;

    assign pos_clip = !((&sum_reg[SUM_W-1:POS_W-1]) || (~|sum_reg[SUM_W-1:POS_W-1]));
    assign vel_clip = !((&sum_reg[SUM_W-1:VEL_W-1]) || (~|sum_reg[SUM_W-1:VEL_W-1]));
    assign pos_sat  = !pos_clip ? sum_reg[POS_W-1:0]
                    : (sum_reg[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                        : {1'b0, {(POS_W-1){1'b1}}});
    assign vel_sat  = !vel_clip ? sum_reg[VEL_W-1:0]
                    : (sum_reg[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                        : {1'b0, {(VEL_W-1){1'b1}}});

    always_comb
    begin
        px_next  = px_reg;
        py_next  = py_reg;
        vx_next  = vx_reg;
        vy_next  = vy_reg;
        sat_next = clear_sat ? 1'b0 : sat_reg;
        if (active)
        begin
            case (ctl.uc.wr_op)
                WR_VEL:
                begin
                    if (ctl.axis)
                    begin
                        vy_next = vel_sat;
                    end
                    else
                    begin
                        vx_next = vel_sat;
                    end
                    sat_next = sat_reg | vel_clip;
                end
                WR_POS:
                begin
                    if (ctl.axis)
                    begin
                        py_next = pos_sat;
                    end
                    else
                    begin
                        px_next = pos_sat;
                    end
                    sat_next = sat_reg | pos_clip;
                end
                WR_COMMIT:
                begin
                    if (load_en)
                    begin
                        px_next = load_pos_x;
                        py_next = load_pos_y;
                        vx_next = load_vel_x;
                        vy_next = load_vel_y;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg  <= '0;
            py_reg  <= '0;
            vx_reg  <= '0;
            vy_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        dv_reg   <= dv_next;
    end

    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign vel_x     = vx_reg;
    assign vel_y     = vy_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

[rtl/core/point_mass_integrator_2d.sv]
// A Verlet-like or RK step runs the Verlet program, symplectic Euler its own program,
// and load, clear, frozen or unknown items run only the common tail; a new beat is taken
// the cycle after the result is registered, so one item is never begun before the last.
// Step time is set by one shared 25x33 multiplier: two passes per product, three
// products per axis for Verlet-like and two for Euler.
// Reset clears state, trail counters and configuration to defaults, not the trail memory.
`default_nettype none

module point_mass_integrator_2d
    import pmi_pkg::*;
#(
    parameter int TRAIL_DEPTH = TRAIL_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // accel_x, accel_y, load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, trail_points, trail_slot, saturated, zero pad
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int HEAD_W = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
    localparam int FILL_W = $clog2(TRAIL_DEPTH + 1);

    logic [DT_W-1:0]     timestep_reg, timestep_next;
    logic [METHOD_W-1:0] method_reg, method_next;
    logic                moves_reg, moves_next;
    logic                trail_en_reg, trail_en_next;

    logic [KIND_W-1:0]          kind_reg;
    logic signed [ACC_IN_W-1:0] accel_x_reg, accel_y_reg;
    logic signed [POS_W-1:0]    load_pos_x_reg, load_pos_y_reg;
    logic signed [VEL_W-1:0]    load_vel_x_reg, load_vel_y_reg;

    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic             accept;
    logic             busy;
    logic             emit;
    logic             emit_ok;
    logic             commit;
    logic             trail_we;
    logic [UPC_W-1:0] entry;
    seq_ctl_t         ctl;

    logic signed [POS_W-1:0] pos_x, pos_y;
    logic signed [VEL_W-1:0] vel_x, vel_y;
    logic                    saturated;
    logic [31:0]             head_ext, fill_ext;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && !busy;
    assign emit_ok       = !out_valid_reg || m_axis_tready;

    // A moving step picks its program; every other item goes straight to the tail.
    always_comb
    begin
        if ((s_axis_tuser == KIND_STEP) && moves_reg)
        begin
            entry = (method_reg == METHOD_EULER) ? UA_EULER : UA_VERLET;
        end
        else
        begin
            entry = UA_COMMIT;
        end
    end

    pmi_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .entry   (entry),
        .emit_ok (emit_ok),
        .busy    (busy),
        .emit    (emit),
        .ctl     (ctl)
    );

    pmi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .active     (busy),
        .clear_sat  (accept),
        .load_en    (kind_reg == KIND_LOAD),
        .timestep   (timestep_reg),
        .accel_x    (accel_x_reg),
        .accel_y    (accel_y_reg),
        .load_pos_x (load_pos_x_reg),
        .load_pos_y (load_pos_y_reg),
        .load_vel_x (load_vel_x_reg),
        .load_vel_y (load_vel_y_reg),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .saturated  (saturated)
    );

    assign commit   = busy && (ctl.uc.wr_op == WR_COMMIT);
    assign trail_we = commit && (kind_reg == KIND_STEP) && moves_reg && trail_en_reg;

    pmi_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (TRAIL_DEPTH)
    ) u_trail (
        .clk   (clk),
        .we    (trail_we),
        .waddr (head_reg),
        .wdata ({pos_y, pos_x}),
        .raddr (head_reg),
        .rdata ()
    );

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (commit && (kind_reg == KIND_CLEAR))
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (trail_we)
        begin
            head_next = (head_reg == HEAD_W'(TRAIL_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (fill_reg != FILL_W'(TRAIL_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        timestep_next = timestep_reg;
        method_next   = method_reg;
        moves_next    = moves_reg;
        trail_en_next = trail_en_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMESTEP: timestep_next = cfg_data[DT_W-1:0];
                CFG_METHOD:   method_next   = cfg_data[METHOD_W-1:0];
                CFG_MOVES:    moves_next    = cfg_data[0];
                CFG_TRAIL:    trail_en_next = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign head_ext = 32'(head_reg);
    assign fill_ext = 32'(fill_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, saturated, head_ext[SLOT_W-1:0],
                              fill_ext[POINTS_W-1:0], vel_y, vel_x, pos_y, pos_x};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timestep_reg  <= TIMESTEP_RST;
            method_reg    <= METHOD_EULER;
            moves_reg     <= 1'b1;
            trail_en_reg  <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timestep_reg  <= timestep_next;
            method_reg    <= method_next;
            moves_reg     <= moves_next;
            trail_en_reg  <= trail_en_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            kind_reg       <= s_axis_tuser;
            accel_x_reg    <= s_axis_tdata[31:0];
            accel_y_reg    <= s_axis_tdata[63:32];
            load_pos_x_reg <= s_axis_tdata[111:64];
            load_pos_y_reg <= s_axis_tdata[159:112];
            load_vel_x_reg <= s_axis_tdata[199:160];
            load_vel_y_reg <= s_axis_tdata[239:200];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[bench/point_mass_integrator_2d_tb.sv]
// Self-checking testbench for the 2D point-mass integrator with a built-in motion predictor.
`timescale 1ns / 100ps

module point_mass_integrator_2d_tb
    import pmi_pkg::*;
();

    localparam int RX_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT     = 3000;
    localparam int REPORT_MAX     = 10;
    localparam int PHASE_ITEMS    = 65;
    localparam int NUM_PHASES     = 8;

    // Codes the block treats without a name of its own.
    localparam logic [KIND_W-1:0]   KIND_UNKNOWN  = 2'd3;
    localparam logic [METHOD_W-1:0] METHOD_VERLET = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_RK     = 2'd2;
    localparam logic [METHOD_W-1:0] METHOD_SPARE  = 2'd3;

    // Input beat: kind rides in tuser, the rest packs into tdata from accel_x up.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VEL_W-1:0]    load_vel_y;
        logic [VEL_W-1:0]    load_vel_x;
        logic [POS_W-1:0]    load_pos_y;
        logic [POS_W-1:0]    load_pos_x;
        logic [ACC_IN_W-1:0] accel_y;
        logic [ACC_IN_W-1:0] accel_x;
    } motion_cmd_t;

    // Result beat, pos_x in the lowest bits.
    typedef struct packed {
        logic                saturated;
        logic [SLOT_W-1:0]   trail_slot;
        logic [POINTS_W-1:0] trail_points;
        logic [VEL_W-1:0]    vel_y;
        logic [VEL_W-1:0]    vel_x;
        logic [POS_W-1:0]    pos_y;
        logic [POS_W-1:0]    pos_x;
    } motion_state_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    point_mass_integrator_2d u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    motion_cmd_t   motion_cmds[$];
    motion_state_t predicted_motion[$];
    motion_cmd_t   cmd_on_bus;

    int src_idle_pct = 0;
    int rx_stall_pct = 0;
    int error_count  = 0;
    int report_count = 0;
    int idle_run     = 0;
    int hold_left    = 0;
    logic hold_kick  = 1'b0;

    // Predictor copy of the configuration and the point state.
    logic [DT_W-1:0]            pt_dt = TIMESTEP_RST;
    logic [METHOD_W-1:0]        pt_method = METHOD_EULER;
    logic                       pt_moves = 1'b1;
    logic                       pt_trail = 1'b0;
    logic signed [POS_W-1:0]    pt_pos_x = '0;
    logic signed [POS_W-1:0]    pt_pos_y = '0;
    logic signed [VEL_W-1:0]    pt_vel_x = '0;
    logic signed [VEL_W-1:0]    pt_vel_y = '0;
    logic [POINTS_W-1:0]        pt_fill = '0;
    logic [SLOT_W-1:0]          pt_slot = '0;

    task automatic queue_cmd(input motion_cmd_t c);
        motion_cmds.insert(motion_cmds.size(), c);
    endtask

    // floor(x * dt / 2^16), exact.
    function automatic logic signed [127:0] scale_dt(input logic signed [127:0] x,
                                                     input logic [DT_W-1:0] dt);
        logic signed [127:0] prod;
        prod = x * $signed({96'd0, dt});
        return prod >>> Q_FRAC;
    endfunction

    function automatic logic signed [127:0] clip_to(input logic signed [127:0] x, input int w);
        logic signed [127:0] top;
        top = (128'sd1 <<< (w - 1)) - 128'sd1;
        if (x > top)
            return top;
        if (x < -top - 128'sd1)
            return -top - 128'sd1;
        return x;
    endfunction

    task automatic move_axis(inout logic signed [POS_W-1:0] p, inout logic signed [VEL_W-1:0] v,
                             input logic [ACC_IN_W-1:0] a, inout logic hit);
        logic signed [127:0] dv, half, sum, lim;
        dv = scale_dt(128'($signed(a)), pt_dt);
        if (pt_method == METHOD_EULER)
        begin
            sum = 128'(v) + dv;
            lim = clip_to(sum, VEL_W);
            hit = hit | (lim != sum);
            v = lim[VEL_W-1:0];
            sum = 128'(p) + scale_dt(128'(v), pt_dt);
            lim = clip_to(sum, POS_W);
            hit = hit | (lim != sum);
            p = lim[POS_W-1:0];
        end
        else
        begin
            // Position uses the old velocity plus half of dv*dt, then velocity moves.
            half = scale_dt(dv, pt_dt) >>> 1;
            sum = 128'(p) + scale_dt(128'(v), pt_dt) + half;
            lim = clip_to(sum, POS_W);
            hit = hit | (lim != sum);
            p = lim[POS_W-1:0];
            sum = 128'(v) + dv;
            lim = clip_to(sum, VEL_W);
            hit = hit | (lim != sum);
            v = lim[VEL_W-1:0];
        end
    endtask

    task automatic advance_point(input motion_cmd_t cmd, output motion_state_t res);
        logic hit;
        hit = 1'b0;
        case (cmd.kind)
            KIND_STEP:
                if (pt_moves)
                begin
                    move_axis(pt_pos_x, pt_vel_x, cmd.accel_x, hit);
                    move_axis(pt_pos_y, pt_vel_y, cmd.accel_y, hit);
                    if (pt_trail)
                    begin
                        pt_slot = SLOT_W'((int'(pt_slot) + 1) % TRAIL_DEPTH_DEF);
                        if (pt_fill < TRAIL_DEPTH_DEF)
                            pt_fill = pt_fill + 1'b1;
                    end
                end
            KIND_LOAD:
            begin
                pt_pos_x = cmd.load_pos_x;
                pt_pos_y = cmd.load_pos_y;
                pt_vel_x = cmd.load_vel_x;
                pt_vel_y = cmd.load_vel_y;
            end
            KIND_CLEAR:
            begin
                pt_fill = '0;
                pt_slot = '0;
            end
            default: ;
        endcase
        res.pos_x        = pt_pos_x;
        res.pos_y        = pt_pos_y;
        res.vel_x        = pt_vel_x;
        res.vel_y        = pt_vel_y;
        res.trail_points = pt_fill;
        res.trail_slot   = pt_slot;
        res.saturated    = hit;
    endtask

    function automatic motion_cmd_t op_cmd(input logic [KIND_W-1:0] kind);
        motion_cmd_t c;
        c.kind       = kind;
        c.accel_x    = $urandom;
        c.accel_y    = $urandom;
        c.load_pos_x = POS_W'({$urandom, $urandom});
        c.load_pos_y = POS_W'({$urandom, $urandom});
        c.load_vel_x = VEL_W'({$urandom, $urandom});
        c.load_vel_y = VEL_W'({$urandom, $urandom});
        return c;
    endfunction

    function automatic motion_cmd_t step_cmd(input logic [ACC_IN_W-1:0] ax,
                                             input logic [ACC_IN_W-1:0] ay);
        motion_cmd_t c;
        c = op_cmd(KIND_STEP);
        c.accel_x = ax;
        c.accel_y = ay;
        return c;
    endfunction

    function automatic motion_cmd_t load_cmd(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                             input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy);
        motion_cmd_t c;
        c = op_cmd(KIND_LOAD);
        c.load_pos_x = px;
        c.load_pos_y = py;
        c.load_vel_x = vx;
        c.load_vel_y = vy;
        return c;
    endfunction

    function automatic logic [ACC_IN_W-1:0] rand_accel();
        logic [31:0] r;
        int sel;
        r = $urandom;
        sel = $urandom_range(99);
        if (sel < 60)
            return {{14{r[17]}}, r[17:0]};
        if (sel < 85)
            return r;
        case (r[1:0])
            2'd0:    return 32'h7FFF_FFFF;
            2'd1:    return 32'h8000_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return r[POS_W-1:0];
            1:       return {{POS_W-32{1'b1}}, 32'h8000_0000} ^ (r[0] ? '1 : '0);
            default: return {{POS_W-34{r[33]}}, r[33:0]};
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] rand_vel();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return r[VEL_W-1:0];
            1:       return {1'b1, {VEL_W-1{1'b0}}} ^ (r[0] ? '1 : '0);
            default: return {{VEL_W-26{r[25]}}, r[25:0]};
        endcase
    endfunction

    // Mostly steps with random content; loads, clears and the unknown kind mixed in.
    function automatic motion_cmd_t rand_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 72)
            return step_cmd(rand_accel(), rand_accel());
        if (sel < 86)
            return load_cmd(rand_pos(), rand_pos(), rand_vel(), rand_vel());
        if (sel < 94)
            return op_cmd(KIND_CLEAR);
        return op_cmd(KIND_UNKNOWN);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TIMESTEP: pt_dt = val;
            CFG_METHOD:   pt_method = val[METHOD_W-1:0];
            CFG_MOVES:    pt_moves = val[0];
            CFG_TRAIL:    pt_trail = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] dt, input logic [31:0] meth,
                              input logic [31:0] mv, input logic [31:0] tr);
        write_reg(CFG_TIMESTEP, dt);
        write_reg(CFG_METHOD, meth);
        write_reg(CFG_MOVES, mv);
        write_reg(CFG_TRAIL, tr);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (motion_cmds.size() != 0 || s_axis_tvalid || predicted_motion.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    // Sender: predicts on every accepted beat, then offers the next command.
    always @(posedge clk)
    begin
        motion_state_t res;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_point(cmd_on_bus, res);
                predicted_motion.insert(predicted_motion.size(), res);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (motion_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    cmd_on_bus = motion_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cmd_on_bus[IN_DATA_W-1:0];
                    s_axis_tuser  <= cmd_on_bus.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= RX_HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks each result beat against the oldest prediction.
    always @(posedge clk)
    begin
        motion_state_t got, want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(motion_state_t)-1:0];
                if (predicted_motion.size() == 0)
                begin
                    error_count++;
                    if (report_count < REPORT_MAX)
                        $display("%t: result beat with no prediction waiting: %h", $realtime,
                                 got);
                    report_count++;
                end
                else
                begin
                    want = predicted_motion.pop_front();
                    if (got.pos_x != want.pos_x || got.pos_y != want.pos_y ||
                        got.vel_x != want.vel_x || got.vel_y != want.vel_y ||
                        got.trail_points != want.trail_points ||
                        got.trail_slot != want.trail_slot || got.saturated != want.saturated)
                    begin
                        error_count++;
                        if (report_count < REPORT_MAX)
                        begin
                            $display("%t: mismatch", $realtime);
                            $display("  expected pos %h %h vel %h %h pts %0d slot %0d sat %b",
                                     want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                                     want.trail_points, want.trail_slot, want.saturated);
                            $display("  actual   pos %h %h vel %h %h pts %0d slot %0d sat %b",
                                     got.pos_x, got.pos_y, got.vel_x, got.vel_y,
                                     got.trail_points, got.trail_slot, got.saturated);
                        end
                        report_count++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && !hold_kick &&
                             ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog on cycles without any beat moving.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_run <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_run <= 0;
        else if (idle_run >= IDLE_LIMIT)
        begin
            $display("point_mass_integrator_2d verification failed");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        int src_plan[NUM_PHASES];
        int rx_plan[NUM_PHASES];
        logic [31:0] dt_val, junk;
        src_plan = '{0, 69, 0, 24, 0, 69, 0, 24};
        rx_plan  = '{0, 0, 69, 24, 0, 0, 69, 24};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, default configuration first: extremes, saturation, unknown kind.
        queue_cmd(step_cmd('0, '0));
        queue_cmd(step_cmd(32'h0001_0000, 32'hFFFF_0000));
        queue_cmd(load_cmd({1'b0, {POS_W-1{1'b1}}}, {1'b1, {POS_W-1{1'b0}}},
                           {1'b0, {VEL_W-1{1'b1}}}, {1'b1, {VEL_W-1{1'b0}}}));
        queue_cmd(step_cmd(32'h7FFF_FFFF, 32'h8000_0000));
        queue_cmd(op_cmd(KIND_UNKNOWN));
        queue_cmd(load_cmd('0, '0, '0, '0));
        wait_idle();

        set_config(32'h0001_0000, 32'(METHOD_VERLET), 32'd1, 32'd1);
        queue_cmd(step_cmd(32'h0001_0000, 32'h0000_8000));
        queue_cmd(step_cmd(32'h7FFF_FFFF, 32'h8000_0000));
        queue_cmd(op_cmd(KIND_CLEAR));
        queue_cmd(step_cmd(rand_accel(), rand_accel()));
        wait_idle();

        // Method code 3 acts as Verlet-like; largest timestep.
        set_config(32'hFFFF_FFFF, 32'(METHOD_SPARE), 32'd1, 32'd1);
        queue_cmd(load_cmd(rand_pos(), rand_pos(), rand_vel(), rand_vel()));
        queue_cmd(step_cmd(32'h7FFF_FFFF, 32'h8000_0000));
        queue_cmd(step_cmd(32'h8000_0000, 32'h7FFF_FFFF));
        queue_cmd(step_cmd(rand_accel(), rand_accel()));
        wait_idle();

        set_config(32'd0, 32'(METHOD_RK), 32'd1, 32'd1);
        queue_cmd(step_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        wait_idle();

        // Frozen point: steps change nothing, loads and clears still act.
        set_config(32'h0001_0000, 32'(METHOD_EULER), 32'd0, 32'd1);
        queue_cmd(step_cmd(32'h7FFF_FFFF, 32'h8000_0000));
        queue_cmd(load_cmd(rand_pos(), rand_pos(), rand_vel(), rand_vel()));
        queue_cmd(op_cmd(KIND_CLEAR));
        queue_cmd(op_cmd(KIND_UNKNOWN));
        wait_idle();

        set_config(32'h0001_0000, 32'(METHOD_EULER), 32'd1, 32'd0);
        queue_cmd(step_cmd(32'h0000_4000, 32'hFFFF_C000));
        wait_idle();

        // Random phases with different idling and configurations.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case ($urandom_range(5))
                0:       dt_val = 32'h0001_0000;
                1:       dt_val = 32'd0;
                2:       dt_val = 32'hFFFF_FFFF;
                3:       dt_val = $urandom_range(1, 32'h0004_0000);
                4:       dt_val = $urandom;
                default: dt_val = $urandom_range(32'h100, 32'h1_0000);
            endcase
            // Upper bits of the narrow registers are sometimes set and must be ignored.
            junk = ($urandom_range(3) == 0) ? ($urandom & 32'hFFFF_FFFC) : 32'd0;
            set_config(dt_val, junk | $urandom_range(3),
                       junk | ($urandom_range(9) != 0), junk | $urandom_range(1));
            src_idle_pct = src_plan[p];
            rx_stall_pct = rx_plan[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_cmd(rand_cmd());
            if (p == 4)
            begin
                // The sender keeps offering while the receiver holds off.
                hold_kick = 1'b1;
                @(negedge clk);
                hold_kick = 1'b0;
            end
            wait_idle();
        end

        // Trail recording from a cleared trail, then a clear in the middle of a run.
        src_idle_pct = 0;
        rx_stall_pct = 0;
        set_config(32'h0000_0100, 32'(METHOD_EULER), 32'd1, 32'd1);
        queue_cmd(op_cmd(KIND_CLEAR));
        for (int i = 0; i < 8; i++)
            queue_cmd(step_cmd(rand_accel(), rand_accel()));
        queue_cmd(op_cmd(KIND_CLEAR));
        queue_cmd(step_cmd(rand_accel(), rand_accel()));
        wait_idle();

        repeat (30) @(posedge clk);
        if (predicted_motion.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("point_mass_integrator_2d verification clean");
        else
            $display("point_mass_integrator_2d verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/pmi_pkg.sv
rtl/core/pmi_ram.sv
rtl/core/pmi_seq.sv
rtl/core/pmi_dp.sv
rtl/core/point_mass_integrator_2d.sv
bench/point_mass_integrator_2d_tb.sv
